### rtl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg: shared types and codes for the sorted index list insert core
// Command and status codes, payload field widths and payload types.
// ----------------------------------------------------------------------------
package sil_pkg;

   localparam int VALUE_W   = 7;
   localparam int COMMAND_W = 2;
   localparam int STATUS_W  = 2;

   typedef logic [COMMAND_W-1:0] command_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [VALUE_W-1:0]   value_type;

   localparam command_type CMD_INSERT = 2'd0;
   localparam command_type CMD_CLEAR  = 2'd1;
   localparam command_type CMD_READ   = 2'd2;

   localparam status_type ST_INSERTED  = 2'd0;
   localparam status_type ST_DUPLICATE = 2'd1;
   localparam status_type ST_DROPPED   = 2'd2;
   localparam status_type ST_OTHER     = 2'd3;

endpackage

### rtl/sil_ram.sv
// ----------------------------------------------------------------------------
// sil_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sorted_index_list_insert_core.sv
// ----------------------------------------------------------------------------
// sorted_index_list_insert_core: ascending linked list over a value-indexed
// node table. Commands insert a value, clear the list or read an entry's
// successor link. The link table lives in one RAM walked one node at a time.
// ----------------------------------------------------------------------------
//  channel   ports                                 handshake
//  request   req_command, req_value                start & !busy
//  response  rsp_status, rsp_head_index/_valid,    rsp_valid, one cycle,
//            rsp_link_index/_valid                 cannot be held off
//
//  Clear and out-of-range or head inserts go from S_EXEC to S_DONE; a read
//  waits in S_RWAIT. A walking insert visits each node via S_CHECK and S_WAIT
//  (RAM read latency), up to MAX_WALK link reads, and splices in S_LINK.
//  After reset the link RAM is swept to end marks, with busy high until every
//  entry is written and the first transaction can be taken.
//  busy stays high from acceptance through the response strobe cycle.
// ----------------------------------------------------------------------------
module sorted_index_list_insert_core #(
   parameter int NUM_VALUES = 128,
   parameter int MAX_WALK   = 121
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sil_pkg::command_type req_command,
   input  sil_pkg::value_type   req_value,
   output logic                 rsp_valid,
   output sil_pkg::status_type  rsp_status,
   output sil_pkg::value_type   rsp_head_index,
   output logic                 rsp_head_valid,
   output sil_pkg::value_type   rsp_link_index,
   output logic                 rsp_link_valid
);

   import sil_pkg::*;

   localparam int IW = $clog2(NUM_VALUES);
   localparam int LW = $clog2(NUM_VALUES + 1);
   localparam int CW = (LW > VALUE_W) ? LW : VALUE_W;
   localparam int KW = $clog2(MAX_WALK + 1);

   localparam logic [2:0] S_SWEEP = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_LINK  = 3'd5;
   localparam logic [2:0] S_RWAIT = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [LW-1:0] END_MARK = LW'(NUM_VALUES);

   logic [2:0]     state_ff, state_in;
   command_type    cmd_ff, cmd_in;
   value_type      val_ff, val_in;
   logic [IW-1:0]  cur_ff, cur_in;
   logic [KW-1:0]  walk_ff, walk_in;
   logic [IW-1:0]  sweep_ff, sweep_in;
   logic [IW-1:0]  head_ff, head_in;
   logic           nonempty_ff, nonempty_in;
   status_type     status_ff, status_in;
   value_type      link_idx_ff, link_idx_in;
   logic           link_vld_ff, link_vld_in;

   logic           wr_en, rd_en;
   logic [IW-1:0]  wr_addr, rd_addr;
   logic [LW-1:0]  wr_data, rd_data;

   logic [CW-1:0]  val_cw, cur_cw, head_cw, rd_cw, end_cw;
   logic           val_in_range;

   sil_ram #(
      .WIDTH (LW),
      .DEPTH (NUM_VALUES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign val_cw       = CW'(val_ff);
   assign cur_cw       = CW'(cur_ff);
   assign head_cw      = CW'(head_ff);
   assign rd_cw        = CW'(rd_data);
   assign end_cw       = CW'(NUM_VALUES);
   assign val_in_range = val_cw < end_cw;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      val_in      = val_ff;
      cur_in      = cur_ff;
      walk_in     = walk_ff;
      sweep_in    = sweep_ff;
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      status_in   = status_ff;
      link_idx_in = link_idx_ff;
      link_vld_in = link_vld_ff;
      wr_en       = 1'b0;
      wr_addr     = IW'(val_ff);
      wr_data     = END_MARK;
      rd_en       = 1'b0;
      rd_addr     = cur_ff;

      case (state_ff)
         S_SWEEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            sweep_in = IW'(sweep_ff + 1'b1);
            if (sweep_ff == IW'(NUM_VALUES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               val_in   = req_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            link_idx_in = '0;
            link_vld_in = 1'b0;
            status_in   = ST_OTHER;
            state_in    = S_DONE;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (!val_in_range) begin
                     status_in = ST_DROPPED;
                  end else if (!nonempty_ff) begin
                     wr_en       = 1'b1;
                     head_in     = IW'(val_ff);
                     nonempty_in = 1'b1;
                     status_in   = ST_INSERTED;
                  end else if (val_cw < head_cw) begin
                     wr_en     = 1'b1;
                     wr_data   = LW'(head_ff);
                     head_in   = IW'(val_ff);
                     status_in = ST_INSERTED;
                  end else begin
                     cur_in   = head_ff;
                     walk_in  = '0;
                     state_in = S_CHECK;
                  end
               end
               CMD_CLEAR: begin
                  nonempty_in = 1'b0;
                  head_in     = '0;
               end
               CMD_READ: begin
                  if (val_in_range) begin
                     rd_en    = 1'b1;
                     rd_addr  = IW'(val_ff);
                     state_in = S_RWAIT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_CHECK: begin
            // node above the value never occurs on a sound chain; drop as the
            // walk would after running to its limit
            if (walk_ff == KW'(MAX_WALK) || cur_cw >= end_cw || val_cw < cur_cw) begin
               status_in = ST_DROPPED;
               state_in  = S_DONE;
            end else if (val_cw == cur_cw) begin
               status_in = ST_DUPLICATE;
               state_in  = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (rd_cw >= end_cw) begin
               wr_en     = 1'b1;
               status_in = ST_INSERTED;
               state_in  = S_LINK;
            end else if (val_cw < rd_cw) begin
               wr_en     = 1'b1;
               wr_data   = rd_data;
               status_in = ST_INSERTED;
               state_in  = S_LINK;
            end else begin
               cur_in   = IW'(rd_data);
               walk_in  = KW'(walk_ff + 1'b1);
               state_in = S_CHECK;
            end
         end
         S_LINK: begin
            // splice predecessor onto the new node
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = LW'(val_ff);
            state_in = S_DONE;
         end
         S_RWAIT: begin
            if (rd_cw < end_cw) begin
               link_idx_in = VALUE_W'(rd_data);
               link_vld_in = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_SWEEP;
         sweep_ff    <= '0;
         walk_ff     <= '0;
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         walk_ff     <= walk_in;
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      cur_ff      <= cur_in;
      status_ff   <= status_in;
      link_idx_ff <= link_idx_in;
      link_vld_ff <= link_vld_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_DONE);
   assign rsp_status     = status_ff;
   assign rsp_head_index = nonempty_ff ? VALUE_W'(head_ff) : '0;
   assign rsp_head_valid = nonempty_ff;
   assign rsp_link_index = link_idx_ff;
   assign rsp_link_valid = link_vld_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      walk_ff <= KW'(MAX_WALK))
      else $error("walk count past limit");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !wr_en)
      else $error("link table written outside a transaction");

   a_link_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_link_valid) |-> (rsp_status == ST_OTHER))
      else $error("link reported for an insert");

endmodule

### verif/sil_list_checker.sv
// ----------------------------------------------------------------------------
// sil_list_checker: scoreboard for the sorted index list insert core
// Watches the request and response channels, keeps its own copy of the head,
// the non-empty flag and the link table, predicts the reply for each accepted
// transaction and compares every response field with the oldest prediction.
// ----------------------------------------------------------------------------
module sil_list_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  sil_pkg::command_type req_command,
   input  sil_pkg::value_type   req_value,
   input  logic                 rsp_valid,
   input  sil_pkg::status_type  rsp_status,
   input  sil_pkg::value_type   rsp_head_index,
   input  logic                 rsp_head_valid,
   input  sil_pkg::value_type   rsp_link_index,
   input  logic                 rsp_link_valid,
   output int                   errors,
   output int                   pending
);

   import sil_pkg::*;

   localparam int NUM_VALUES = 128;
   localparam int MAX_WALK   = 121;
   localparam logic [7:0] END_MARK = 8'd128;

   typedef struct packed {
      status_type status;
      value_type  head_index;
      logic       head_valid;
      value_type  link_index;
      logic       link_valid;
   } list_reply_type;

   logic [7:0]     link_table [NUM_VALUES];
   value_type      head_entry;
   logic           list_live;
   list_reply_type reply_queue [$];
   int             mismatches = 0;

   function automatic status_type insert_value(value_type v);
      logic [7:0] cur;
      logic [7:0] nx;
      if (!list_live) begin
         head_entry    = v;
         link_table[v] = END_MARK;
         list_live     = 1'b1;
         return ST_INSERTED;
      end
      if (v < head_entry) begin
         link_table[v] = {1'b0, head_entry};
         head_entry    = v;
         return ST_INSERTED;
      end
      cur = {1'b0, head_entry};
      for (int k = 0; k < MAX_WALK; k++) begin
         if (cur >= END_MARK)
            return ST_DROPPED;
         if ({1'b0, v} == cur)
            return ST_DUPLICATE;
         // below the current node nothing can be decided; walk burns a step
         if ({1'b0, v} > cur) begin
            nx = link_table[cur[6:0]];
            if (nx >= END_MARK) begin
               link_table[v]        = END_MARK;
               link_table[cur[6:0]] = {1'b0, v};
               return ST_INSERTED;
            end
            if ({1'b0, v} < nx) begin
               link_table[v]        = nx;
               link_table[cur[6:0]] = {1'b0, v};
               return ST_INSERTED;
            end
            cur = nx;
         end
      end
      return ST_DROPPED;
   endfunction

   function automatic list_reply_type predict_reply(command_type cmd, value_type v);
      list_reply_type r;
      r        = '0;
      r.status = ST_OTHER;
      case (cmd)
         CMD_INSERT: r.status = insert_value(v);
         CMD_CLEAR: begin
            // links stay as they are, only the head goes
            list_live  = 1'b0;
            head_entry = '0;
         end
         CMD_READ: begin
            if (link_table[v] < END_MARK) begin
               r.link_index = link_table[v][6:0];
               r.link_valid = 1'b1;
            end
         end
         default: ;
      endcase
      r.head_index = list_live ? head_entry : '0;
      r.head_valid = list_live;
      return r;
   endfunction

   task automatic check_field(string label, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         for (int i = 0; i < NUM_VALUES; i++)
            link_table[i] = END_MARK;
         head_entry = '0;
         list_live  = 1'b0;
         reply_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (reply_queue.size() == 0) begin
               $display("%0t: stray response, expected none, actual status %0d head %0d",
                        $time, rsp_status, rsp_head_index);
               mismatches++;
            end else begin
               want = reply_queue.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_status));
               check_field("head_index", 8'(want.head_index), 8'(rsp_head_index));
               check_field("head_valid", 8'(want.head_valid), 8'(rsp_head_valid));
               check_field("link_index", 8'(want.link_index), 8'(rsp_link_index));
               check_field("link_valid", 8'(want.link_valid), 8'(rsp_link_valid));
            end
         end
         if (start && !busy)
            reply_queue.push_back(predict_reply(req_command, req_value));
      end
      errors  <= mismatches;
      pending <= reply_queue.size();
   end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the sorted index list insert core
// Drives directed and random command sequences (list fills, inserts, reads,
// clears, unused codes) with random idle gaps; the checker predicts and
// compares every response and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import sil_pkg::*;

   localparam command_type CMD_UNUSED = 2'd3;
   localparam int ITEM_GOAL = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   command_type req_command = CMD_INSERT;
   value_type   req_value = '0;
   logic        busy;
   logic        rsp_valid;
   status_type  rsp_status;
   value_type   rsp_head_index;
   logic        rsp_head_valid;
   value_type   rsp_link_index;
   logic        rsp_link_valid;
   int          errors;
   int          pending;

   int items_sent = 0;
   int idle_mode  = 1;
   int order_buf [128];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_index_list_insert_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_head_index (rsp_head_index),
      .rsp_head_valid (rsp_head_valid),
      .rsp_link_index (rsp_link_index),
      .rsp_link_valid (rsp_link_valid)
   );

   sil_list_checker u_list_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_head_index (rsp_head_index),
      .rsp_head_valid (rsp_head_valid),
      .rsp_link_index (rsp_link_index),
      .rsp_link_valid (rsp_link_valid),
      .errors         (errors),
      .pending        (pending)
   );

   // one transaction: optional idle gap, then hold start until accepted
   task automatic issue(command_type cmd, value_type val);
      int gap;
      case (idle_mode)
         0:       gap = 0;
         1:       gap = $urandom_range(0, 11);
         default: gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
      endcase
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // clear, then insert count values: 0 ascending, 1 descending, 2 shuffled
   task automatic fill_list(int count, int order);
      int base;
      int j;
      int tmp;
      base = $urandom_range(0, 128 - count);
      for (int i = 0; i < 128; i++)
         order_buf[i] = i;
      if (order == 2) begin
         for (int i = 127; i > 0; i--) begin
            j            = $urandom_range(0, i);
            tmp          = order_buf[i];
            order_buf[i] = order_buf[j];
            order_buf[j] = tmp;
         end
      end
      issue(CMD_CLEAR, value_type'($urandom_range(0, 127)));
      for (int i = 0; i < count; i++) begin
         case (order)
            0:       issue(CMD_INSERT, value_type'(base + i));
            1:       issue(CMD_INSERT, value_type'(base + count - 1 - i));
            default: issue(CMD_INSERT, value_type'(order_buf[i]));
         endcase
      end
   endtask

   task automatic random_burst(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            issue(CMD_INSERT, value_type'($urandom_range(0, 127)));
         else if (pick < 90)
            issue(CMD_READ, value_type'($urandom_range(0, 127)));
         else if (pick < 95)
            issue(CMD_CLEAR, value_type'($urandom_range(0, 127)));
         else
            issue(CMD_UNUSED, value_type'($urandom_range(0, 127)));
      end
   endtask

   initial begin
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reads, head/middle/tail inserts, duplicate, clear
      idle_mode = 1;
      issue(CMD_READ, 7'd0);
      issue(CMD_READ, 7'd127);
      issue(CMD_INSERT, 7'd64);
      issue(CMD_INSERT, 7'd64);
      issue(CMD_INSERT, 7'd10);
      issue(CMD_INSERT, 7'd127);
      issue(CMD_INSERT, 7'd100);
      issue(CMD_INSERT, 7'd0);
      issue(CMD_INSERT, 7'd127);
      issue(CMD_READ, 7'd10);
      issue(CMD_READ, 7'd127);
      issue(CMD_READ, 7'd0);
      issue(CMD_UNUSED, 7'd85);
      issue(CMD_UNUSED, 7'd42);
      issue(CMD_CLEAR, 7'd0);
      issue(CMD_READ, 7'd64);     // stale link left behind by the clear
      issue(CMD_READ, 7'd5);
      issue(CMD_INSERT, 7'd5);
      issue(CMD_INSERT, 7'd5);
      issue(CMD_READ, 7'd5);
      issue(CMD_INSERT, 7'd127);
      issue(CMD_READ, 7'd5);

      // full ascending fill: values past the walk limit get dropped
      idle_mode = 0;
      fill_list(128, 0);

      while (items_sent < ITEM_GOAL) begin
         idle_mode = $urandom_range(0, 2);
         pick      = $urandom_range(0, 9);
         if (pick == 0)
            issue(CMD_CLEAR, value_type'($urandom_range(0, 127)));
         else if (pick <= 2)
            fill_list($urandom_range(0, 1) ? 128 : $urandom_range(4, 40),
                      $urandom_range(0, 2));
         else
            random_burst($urandom_range(10, 40));
      end
      start <= 1'b0;

      @(posedge clock);
      for (int w = 0; w < 5000 && pending != 0; w++)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("tb: errors");
      $finish;
   end

endmodule
